/* rtl/core/sbrs_pkg.sv */
package sbrs_pkg;

  localparam int SOURCE_COUNT_DEF = 16;
  localparam int BUFFER_BYTES_DEF = 65536;
  localparam int OFFSET_SPAN      = 65536;
  localparam int SEC_PER_MIN      = 60;
  localparam int MIN_PER_HOUR     = 60;
  localparam int HOUR_PER_DAY     = 24;

  localparam int SYNC_W   = 16;
  localparam int SRC_W    = 4;
  localparam int HOUR_W   = 5;
  localparam int MIN_W    = 6;
  localparam int SEC_W    = 6;
  localparam int LEN_W    = 16;
  localparam int PLEN_W   = 17;
  localparam int MASK_W   = 16;
  localparam int OFF_W    = 16;
  localparam int DROP_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_ID     = 2'd0,
    CFG_LOGICAL_LEN = 2'd1,
    CFG_PHYS_LEN    = 2'd2,
    CFG_MASTER_MASK = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    TC_STARTUP = 2'd0,
    TC_SAME    = 2'd1,
    TC_NEXT    = 2'd2,
    TC_GAP     = 2'd3
  } time_class_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
  } stamp_t;

  typedef struct packed {
    logic [SYNC_W-1:0] sync_word;
    logic [SRC_W-1:0]  source_index;
    stamp_t            stamp;
  } header_t;

  typedef struct packed {
    logic              ldone;
    logic              pdone;
    logic [OFF_W-1:0]  offset;
    logic              buffer;
    logic [DROP_W-1:0] dropped;
    logic              fresh;
    logic              full;
  } rec_res_t;

  typedef struct packed {
    logic              misaligned;
    time_class_t       time_class;
    logic              from_master;
    rec_res_t          rec;
  } result_t;

endpackage

/* rtl/core/sample_block_record_sequencer.sv */
// An accepted input request passes the input register, then the result register;
// out_valid rises when the result register is loaded.
// Throughput: one header request per cycle, sustained, while out_ready stays high.
// The time, offset and source-mask state updates for an aligned header in the cycle a
// result is loaded, so the next header sees it with no bubble.
// Reset (rst_n low, synchronous): state cleared, registers at defaults, both stages empty.
module sample_block_record_sequencer #(
  parameter int SOURCE_COUNT = sbrs_pkg::SOURCE_COUNT_DEF,
  parameter int BUFFER_BYTES = sbrs_pkg::BUFFER_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_wr_en,
  input  logic [sbrs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sbrs_pkg::CFG_DAT_W-1:0]   cfg_wdata,
  // header requests
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [sbrs_pkg::SYNC_W-1:0]      in_sync_word,
  input  logic [sbrs_pkg::SRC_W-1:0]       in_source_index,
  input  logic [sbrs_pkg::HOUR_W-1:0]      in_stamp_hour,
  input  logic [sbrs_pkg::MIN_W-1:0]       in_stamp_minute,
  input  logic [sbrs_pkg::SEC_W-1:0]       in_stamp_second,
  // result requests
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_misaligned,
  output logic [1:0]                       out_time_class,
  output logic                             out_logical_done,
  output logic                             out_physical_done,
  output logic                             out_from_master,
  output logic [sbrs_pkg::OFF_W-1:0]       out_record_offset,
  output logic                             out_buffer_select,
  output logic [sbrs_pkg::DROP_W-1:0]      out_dropped_sources,
  output logic                             out_newly_connected,
  output logic                             out_record_full
);
  import sbrs_pkg::*;

  // configuration registers
  logic [SYNC_W-1:0] sync_id_r;
  logic [LEN_W-1:0]  logical_len_r;
  logic [PLEN_W-1:0] phys_len_r;
  logic [MASK_W-1:0] master_mask_r;

  // input stage
  logic    hdr_vld_r;
  header_t hdr_r;

  // result stage
  logic    res_vld_r;
  result_t res_r;
  result_t res_nxt;

  logic        advance;   // input stage hands its header to the result stage
  logic        aligned;
  logic        commit;    // state update for an aligned header
  logic        master;
  time_class_t cls;
  rec_res_t    rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_id_r     <= '0;
      logical_len_r <= LEN_W'(1);
      phys_len_r    <= PLEN_W'(1);
      master_mask_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SYNC_ID:     sync_id_r     <= cfg_wdata[SYNC_W-1:0];
        CFG_LOGICAL_LEN: logical_len_r <= cfg_wdata[LEN_W-1:0];
        CFG_PHYS_LEN:    phys_len_r    <= cfg_wdata[PLEN_W-1:0];
        CFG_MASTER_MASK: master_mask_r <= cfg_wdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Result register frees when empty or drained this cycle; the input register
  // frees when it moves on, so a waiting result never blocks one more header.
  assign advance  = hdr_vld_r && (!res_vld_r || out_ready);
  assign in_ready = !hdr_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_vld_r <= 1'b0;
    end else if (in_ready) begin
      hdr_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hdr_r.sync_word     <= in_sync_word;
      hdr_r.source_index  <= in_source_index;
      hdr_r.stamp.hour    <= in_stamp_hour;
      hdr_r.stamp.minute  <= in_stamp_minute;
      hdr_r.stamp.second  <= in_stamp_second;
    end
  end

  // Masters are only defined for the sources the unit tracks.
  assign master  = (32'(hdr_r.source_index) < SOURCE_COUNT) &&
                   master_mask_r[hdr_r.source_index];
  assign aligned = (hdr_r.sync_word == sync_id_r);
  assign commit  = advance && aligned;

  sbrs_time u_time (
    .clk    (clk),
    .rst_n  (rst_n),
    .stamp  (hdr_r.stamp),
    .commit (commit),
    .master (master),
    .cls    (cls)
  );

  sbrs_record #(
    .SOURCE_COUNT (SOURCE_COUNT),
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_record (
    .clk             (clk),
    .rst_n           (rst_n),
    .commit          (commit),
    .cls             (cls),
    .master          (master),
    .src             (hdr_r.source_index),
    .logical_length  (logical_len_r),
    .physical_length (phys_len_r),
    .res             (rec)
  );

  // A misaligned header reports only the flag; everything else reads zero.
  always_comb begin
    if (aligned) begin
      res_nxt.misaligned  = 1'b0;
      res_nxt.time_class  = cls;
      res_nxt.from_master = master;
      res_nxt.rec         = rec;
    end else begin
      res_nxt             = '0;
      res_nxt.misaligned  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (advance) begin
      res_vld_r <= 1'b1;
    end else if (out_ready) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = res_vld_r;
  assign out_misaligned      = res_r.misaligned;
  assign out_time_class      = res_r.time_class;
  assign out_logical_done    = res_r.rec.ldone;
  assign out_physical_done   = res_r.rec.pdone;
  assign out_from_master     = res_r.from_master;
  assign out_record_offset   = res_r.rec.offset;
  assign out_buffer_select   = res_r.rec.buffer;
  assign out_dropped_sources = res_r.rec.dropped;
  assign out_newly_connected = res_r.rec.fresh;
  assign out_record_full     = res_r.rec.full;

endmodule

/* rtl/core/sbrs_time.sv */
module sbrs_time (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sbrs_pkg::stamp_t     stamp,
  input  logic                 commit,
  input  logic                 master,
  output sbrs_pkg::time_class_t cls
);
  import sbrs_pkg::*;

  logic              known_r;
  logic [HOUR_W-1:0] hour_r;
  logic [MIN_W-1:0]  min_r;
  logic [SEC_W-1:0]  sec_r;

  logic [SEC_W:0]    sec_inc;
  logic [MIN_W:0]    min_inc;
  logic [HOUR_W:0]   hour_inc;
  logic [SEC_W-1:0]  ts;
  logic [MIN_W-1:0]  tm;
  logic [MIN_W-1:0]  min_mod;
  logic [MIN_W-1:0]  min_wrap;
  logic [HOUR_W-1:0] th;
  logic [HOUR_W-1:0] hour_mod;
  logic [HOUR_W-1:0] hour_wrap;
  logic              adopt;

  // expected stamp one second after the held time, each field reduced first
  always_comb begin
    sec_inc  = {1'b0, sec_r} + (SEC_W+1)'(1);
    ts       = (sec_inc >= (SEC_W+1)'(SEC_PER_MIN)) ?
               SEC_W'(sec_inc - (SEC_W+1)'(SEC_PER_MIN)) : sec_inc[SEC_W-1:0];
    min_inc  = {1'b0, min_r} + (MIN_W+1)'(1);
    min_mod  = (min_r >= MIN_W'(MIN_PER_HOUR)) ? min_r - MIN_W'(MIN_PER_HOUR) : min_r;
    min_wrap = (min_inc >= (MIN_W+1)'(MIN_PER_HOUR)) ?
               MIN_W'(min_inc - (MIN_W+1)'(MIN_PER_HOUR)) : min_inc[MIN_W-1:0];
    tm       = (ts == '0) ? min_wrap : min_mod;
    hour_inc = {1'b0, hour_r} + (HOUR_W+1)'(1);
    hour_mod = (hour_r >= HOUR_W'(HOUR_PER_DAY)) ? hour_r - HOUR_W'(HOUR_PER_DAY) : hour_r;
    hour_wrap = (hour_inc >= (HOUR_W+1)'(HOUR_PER_DAY)) ?
                HOUR_W'(hour_inc - (HOUR_W+1)'(HOUR_PER_DAY)) : hour_inc[HOUR_W-1:0];
    th       = (ts == '0 && tm == '0) ? hour_wrap : hour_mod;

    if (!known_r) begin
      cls = TC_STARTUP;
    end else if (stamp.hour == hour_r && stamp.minute == min_r && stamp.second == sec_r) begin
      cls = TC_SAME;
    end else if (stamp.hour == th && stamp.minute == tm && stamp.second == ts) begin
      cls = TC_NEXT;
    end else begin
      cls = TC_GAP;
    end

    adopt = commit && (cls == TC_STARTUP || cls == TC_NEXT || (cls == TC_GAP && master));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      known_r <= 1'b0;
      hour_r  <= '0;
      min_r   <= '0;
      sec_r   <= '0;
    end else if (adopt) begin
      known_r <= 1'b1;
      hour_r  <= stamp.hour;
      min_r   <= stamp.minute;
      sec_r   <= stamp.second;
    end
  end

endmodule

/* rtl/core/sbrs_record.sv */
module sbrs_record #(
  parameter int SOURCE_COUNT = sbrs_pkg::SOURCE_COUNT_DEF,
  parameter int BUFFER_BYTES = sbrs_pkg::BUFFER_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          commit,
  input  sbrs_pkg::time_class_t         cls,
  input  logic                          master,
  input  logic [sbrs_pkg::SRC_W-1:0]    src,
  input  logic [sbrs_pkg::LEN_W-1:0]    logical_length,
  input  logic [sbrs_pkg::PLEN_W-1:0]   physical_length,
  output sbrs_pkg::rec_res_t            res
);
  import sbrs_pkg::*;

  localparam int CAP = (BUFFER_BYTES < OFFSET_SPAN) ? BUFFER_BYTES : OFFSET_SPAN;
  localparam logic [PLEN_W-1:0] LIMIT_CAP = PLEN_W'(CAP);

  logic [OFF_W-1:0]        offset_r, offset_nxt;
  logic                    buffer_r, buffer_nxt;
  logic [SOURCE_COUNT-1:0] conn_r, conn_nxt;
  logic [SOURCE_COUNT-1:0] recv_r, recv_nxt;

  logic [SOURCE_COUNT-1:0] src_bit;
  logic [SOURCE_COUNT-1:0] gone;
  logic [PLEN_W-1:0]       limit;
  logic [PLEN_W-1:0]       sum;
  logic                    valid_src;
  logic                    advance;
  logic                    drop;

  always_comb begin
    valid_src = (32'(src) < SOURCE_COUNT);
    src_bit   = valid_src ? (SOURCE_COUNT'(1) << src) : '0;
    advance   = (cls == TC_NEXT || cls == TC_GAP);
    drop      = (cls == TC_NEXT) || (cls == TC_GAP && master);

    limit = (physical_length < LIMIT_CAP) ? physical_length : LIMIT_CAP;
    sum   = {1'b0, offset_r} + {1'b0, logical_length};

    offset_nxt = offset_r;
    buffer_nxt = buffer_r;
    res.pdone  = 1'b0;
    if (advance) begin
      if (sum >= limit) begin
        offset_nxt = '0;
        buffer_nxt = ~buffer_r;
        res.pdone  = 1'b1;
      end else begin
        offset_nxt = sum[OFF_W-1:0];
      end
    end

    gone     = drop ? (conn_r & ~recv_r) : '0;
    conn_nxt = (conn_r & ~gone) | src_bit;
    recv_nxt = (drop ? '0 : recv_r) | src_bit;

    res.ldone   = advance;
    res.offset  = offset_nxt;
    res.buffer  = buffer_nxt;
    res.dropped = DROP_W'(gone);
    // a source dropped by this very header counts as reconnecting
    res.fresh   = valid_src && (((conn_r & ~gone) & src_bit) == '0);
    res.full    = ((conn_nxt & ~recv_nxt) == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      buffer_r <= 1'b0;
      conn_r   <= '0;
      recv_r   <= '0;
    end else if (commit) begin
      offset_r <= offset_nxt;
      buffer_r <= buffer_nxt;
      conn_r   <= conn_nxt;
      recv_r   <= recv_nxt;
    end
  end

endmodule

/* rtl/core/sbrs_checker.sv */
module sbrs_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             out_misaligned,
  input logic [1:0]                       out_time_class,
  input logic                             out_logical_done,
  input logic                             out_physical_done,
  input logic                             out_from_master,
  input logic [sbrs_pkg::OFF_W-1:0]       out_record_offset,
  input logic [sbrs_pkg::DROP_W-1:0]      out_dropped_sources,
  input logic                             out_newly_connected,
  input logic                             out_record_full
);
  import sbrs_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_record_offset) &&
    $stable(out_time_class) && $stable(out_dropped_sources))
    else $error("stalled result changed");

  // misaligned result carries nothing else
  a_misaligned_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_misaligned |-> out_time_class == TC_STARTUP &&
    !out_logical_done && !out_physical_done && out_record_offset == '0 &&
    out_dropped_sources == '0 && !out_newly_connected && !out_record_full)
    else $error("misaligned result has payload");

  // a wrap is an advance that lands on offset zero
  a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_physical_done |-> out_logical_done && out_record_offset == '0)
    else $error("wrap without advance or nonzero offset");

  // offset only advances, and sources only drop, on next second or gap
  a_advance_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_logical_done || out_dropped_sources != '0) |->
    out_time_class == TC_NEXT || out_time_class == TC_GAP)
    else $error("advance or drop on wrong time class");

  // sources drop on a gap only when a master sent it
  a_gap_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_time_class == TC_GAP && out_dropped_sources != '0 |-> out_from_master)
    else $error("drop on gap from non-master");

endmodule

bind sample_block_record_sequencer sbrs_checker u_sbrs_checker (.*);
